// File: sv/ipc_pkg.sv
// Shared types and constants for the integer partition counter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ipc_pkg;

  // Field widths fixed by the interface.
  localparam int N_W     = 7;
  localparam int COUNT_W = 28;

  // Largest table entry; additions saturate here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_UPDATE,
    ST_DRAIN,
    ST_FINISH
  } ipc_state_t;

  // Commands from the sequencer to the table unit.
  typedef struct packed {
    logic init_wr;  // write the starting count of one at the sum address
    logic upd_rd;   // read sum and sum-minus-part entries for an update
  } ipc_ctrl_t;

endpackage

// File: sv/ipc_table.sv
// Table of partial counts: dual-read, single-write memory with a
// read-modify-write update stage and write-to-read forwarding.
// Depends on ipc_pkg.
`timescale 1ns / 1ps

module ipc_table
  import ipc_pkg::*;
#(
  parameter int MAX_N = 100
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ipc_ctrl_t                     ctrl,
  input  logic [$clog2(((MAX_N < 127) ? MAX_N : 127) + 1)-1:0] addr_s,
  input  logic [$clog2(((MAX_N < 127) ? MAX_N : 127) + 1)-1:0] addr_sk,
  output logic [COUNT_W-1:0]            last_value
);

  localparam int N_EFF = (MAX_N < 127) ? MAX_N : 127;
  localparam int DEPTH = N_EFF + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [COUNT_W-1:0] mem [DEPTH];

  logic [COUNT_W-1:0] rd_a;
  logic [COUNT_W-1:0] rd_b;
  logic [AW-1:0]      addr_a_q;
  logic [AW-1:0]      addr_b_q;
  logic               pend;

  logic               fw_en;
  logic [AW-1:0]      fw_addr;
  logic [COUNT_W-1:0] fw_data;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic [COUNT_W-1:0] op_a;
  logic [COUNT_W-1:0] op_b;
  logic [COUNT_W:0]   sum_wide;
  logic [COUNT_W-1:0] sum_sat;

  // Operands: a write that landed on the same edge as the read is newer
  // than what the memory returned, so take it from the forwarding register.
  always_comb begin
    op_a     = (fw_en && fw_addr == addr_a_q) ? fw_data : rd_a;
    op_b     = (fw_en && fw_addr == addr_b_q) ? fw_data : rd_b;
    sum_wide = {1'b0, op_a} + {1'b0, op_b};
    sum_sat  = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
  end

  // Write port: update results take priority; otherwise an init beat.
  always_comb begin
    wr_en   = pend | ctrl.init_wr;
    wr_addr = pend ? addr_a_q : addr_s;
    wr_data = pend ? sum_sat : COUNT_W'(1);
  end

  // Memory array with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.upd_rd) begin
      rd_a     <= mem[addr_s];
      rd_b     <= mem[addr_sk];
      addr_a_q <= addr_s;
      addr_b_q <= addr_sk;
    end
  end

  // Forwarding copy of the latest write and the final value for the result.
  always_ff @(posedge clk) begin
    fw_addr <= wr_addr;
    fw_data <= wr_data;
    if (wr_en) begin
      last_value <= wr_data;
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      fw_en <= 1'b0;
    end else begin
      pend  <= ctrl.upd_rd;
      fw_en <= wr_en;
    end
  end

endmodule

// File: sv/ipc_seq.sv
// Sequencer: walks part sizes and sums, issues table commands and hands
// the finished count to the output stage. Depends on ipc_pkg.
`timescale 1ns / 1ps

module ipc_seq
  import ipc_pkg::*;
#(
  parameter int MAX_N = 100
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [N_W-1:0]                n_value,
  input  logic                          out_free,
  output logic                          req_stall,
  output logic                          finish,
  output ipc_ctrl_t                     ctrl,
  output logic [$clog2(((MAX_N < 127) ? MAX_N : 127) + 1)-1:0] addr_s,
  output logic [$clog2(((MAX_N < 127) ? MAX_N : 127) + 1)-1:0] addr_sk
);

  localparam int N_EFF = (MAX_N < 127) ? MAX_N : 127;
  localparam int AW    = $clog2(N_EFF + 1);

  ipc_state_t    state;
  ipc_state_t    state_next;
  logic [AW-1:0] n_reg;
  logic [AW-1:0] part_size;
  logic [AW-1:0] sum_index;
  logic [AW-1:0] n_clamped;
  logic          accept;

  // Inputs above the table size use the largest supported number.
  assign n_clamped = (int'(n_value) > N_EFF) ? AW'(N_EFF) : AW'(n_value);
  assign accept    = req_valid && !req_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_INIT;
      end
      ST_INIT: begin
        if (sum_index == n_reg) begin
          state_next = (n_reg <= AW'(1)) ? ST_FINISH : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (sum_index == n_reg && part_size == n_reg) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    req_stall    = (state != ST_IDLE);
    ctrl.init_wr = (state == ST_INIT);
    ctrl.upd_rd  = (state == ST_UPDATE);
    finish       = (state == ST_FINISH);
    addr_s       = sum_index;
    addr_sk      = sum_index - part_size;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters. The init pass already holds the table after part size one,
  // so the update passes start at part size two.
  always_ff @(posedge clk) begin
    if (rst) begin
      part_size <= '0;
      sum_index <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            part_size <= AW'(1);
            sum_index <= '0;
          end
        end
        ST_INIT: begin
          if (sum_index == n_reg) begin
            if (n_reg > AW'(1)) begin
              part_size <= AW'(2);
              sum_index <= AW'(2);
            end
          end else begin
            sum_index <= sum_index + AW'(1);
          end
        end
        ST_UPDATE: begin
          if (sum_index == n_reg) begin
            if (part_size != n_reg) begin
              part_size <= part_size + AW'(1);
              sum_index <= part_size + AW'(1);
            end
          end else begin
            sum_index <= sum_index + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Captured query.
  always_ff @(posedge clk) begin
    if (accept) begin
      n_reg <= n_clamped;
    end
  end

endmodule

// File: sv/integer_partition_counter.sv
// Top level of the integer partition counter: sequencer, table unit and
// output register. Depends on ipc_pkg, ipc_seq and ipc_table.
`timescale 1ns / 1ps

// Usage:
// The request channel (req_valid, req_stall, n_value) takes one number per
// beat; the response channel (rsp_valid, rsp_stall, partition_count_less_one)
// returns the count of its partitions minus one, one beat per request, in
// order. Numbers above MAX_N are treated as MAX_N; zero returns zero.
// Each request fills the table of partial counts from scratch, one table
// update per cycle through the single memory write port: an init pass for
// part size one, then update passes for part sizes two to n and a drain
// step; for n of zero or one only the init pass runs. The next request is
// accepted in the cycle after the result moves into the response register.
// req_stall is high for the whole computation. If the receiver stalls, the
// result waits in the response register while a new request runs; a second
// result then waits in the sequencer until the register frees. Synchronous
// reset returns to idle with no response pending; the table needs
// no clearing pass.

module integer_partition_counter
  import ipc_pkg::*;
#(
  parameter int MAX_N = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [N_W-1:0]     n_value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [COUNT_W-1:0] partition_count_less_one
);

  localparam int N_EFF = (MAX_N < 127) ? MAX_N : 127;
  localparam int AW    = $clog2(N_EFF + 1);

  ipc_ctrl_t          ctrl;
  logic [AW-1:0]      addr_s;
  logic [AW-1:0]      addr_sk;
  logic               finish;
  logic               out_free;
  logic               load;
  logic [COUNT_W-1:0] last_value;

  assign out_free = !rsp_valid || !rsp_stall;
  assign load     = finish && out_free;

  ipc_seq #(
    .MAX_N(MAX_N)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .n_value  (n_value),
    .out_free (out_free),
    .req_stall(req_stall),
    .finish   (finish),
    .ctrl     (ctrl),
    .addr_s   (addr_s),
    .addr_sk  (addr_sk)
  );

  ipc_table #(
    .MAX_N(MAX_N)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .addr_s    (addr_s),
    .addr_sk   (addr_sk),
    .last_value(last_value)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      partition_count_less_one <= last_value - COUNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous work still idle");

  // A new response only appears after the block was busy computing it.
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without a computation");

  // Every partition count is at least one.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    finish |-> last_value != '0)
    else $error("table returned a zero count");

  // The table is never commanded to init and update at once.
  a_ctrl_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.init_wr && ctrl.upd_rd))
    else $error("conflicting table commands");
`endif

endmodule
